>>> hdl/tfd_pkg.sv
// Shared types, constants and the torque-to-mode lookup for the throttle frame deframer.
// Used by the front and back parts, the queue and the top level.
package tfd_pkg;

  localparam logic [7:0] START_BYTE   = 8'hFD;
  localparam logic [2:0] MODE_UNKNOWN = 3'd6;
  localparam int         QDEPTH       = 2;
  localparam int         QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int         QCNT_W       = $clog2(QDEPTH + 1);

  // Byte positions within a frame.
  localparam logic [3:0] POS_SPEED  = 4'd1;
  localparam logic [3:0] POS_WHEEL  = 4'd2;
  localparam logic [3:0] POS_FLAGS  = 4'd3;
  localparam logic [3:0] POS_TORQUE = 4'd5;
  localparam logic [3:0] POS_CHECK  = 4'd6;
  localparam logic [3:0] POS_DONE   = 4'd8;

  localparam int         NUM_MODES  = 6;
  localparam logic [7:0] TORQUE_V4  [NUM_MODES] = '{8'h00, 8'h05, 8'h07, 8'h09, 8'h0B, 8'h0D};
  localparam logic [7:0] TORQUE_V3X [NUM_MODES] = '{8'h00, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0D};

  typedef enum logic [1:0] {
    CFG_FLAG_MASK    = 2'd0,
    CFG_WHEEL_SMALL  = 2'd1,
    CFG_WHEEL_LARGE  = 2'd2,
    CFG_TABLE_SELECT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] flag_mask;
    logic [3:0] wheel_code_small;
    logic [3:0] wheel_code_large;
    logic       torque_table_select;
  } cfg_t;

  // A checked frame waiting to be decoded.
  typedef struct packed {
    logic [7:0] speed;
    logic [3:0] wheel_nib;
    logic [7:0] flags;
    logic [7:0] torque;
  } frame_t;

  // Lowest table index whose entry equals the torque byte, else unknown.
  function automatic logic [2:0] lookup_mode(logic [7:0] torque, logic sel);
    logic [2:0] m;
    logic [7:0] entry;
    m = MODE_UNKNOWN;
    for (int i = NUM_MODES - 1; i >= 0; i--) begin
      entry = sel ? TORQUE_V3X[i] : TORQUE_V4[i];
      if (entry == torque) begin
        m = 3'(i);
      end
    end
    return m;
  endfunction

endpackage

>>> hdl/tfd_if.sv
// Handshake interfaces for the received-byte channel and the result channel.
// Depends on nothing but plain logic types.
interface tfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] speed;
  logic [7:0] flags;
  logic [7:0] torque;
  logic [3:0] wheel_size;
  logic       wheel_known;
  logic [2:0] mode;

  modport source (output valid, output speed, output flags, output torque,
                  output wheel_size, output wheel_known, output mode, input ready);
  modport sink   (input valid, input speed, input flags, input torque,
                  input wheel_size, input wheel_known, input mode, output ready);
endinterface

>>> hdl/tfd_front.sv
// Front part: tracks the byte position, captures frame fields and checks the running XOR.
// Depends on tfd_pkg; pushes checked frames into tfd_queue.
module tfd_front
  import tfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  output logic       push_valid_o,
  output frame_t     push_data_o,
  input  logic       push_ready_i
);

  logic [3:0] pos_q, pos_d, pos_eff;
  logic [7:0] xor_q, xor_d;
  frame_t     fr_q, fr_d;
  logic       accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  // A start byte always restarts the frame and is itself taken as byte zero.
  assign pos_eff    = (in_byte_i == START_BYTE) ? 4'd0 : pos_q;

  always_comb begin
    pos_d = pos_q;
    xor_d = xor_q;
    fr_d  = fr_q;
    if (accept) begin
      if (pos_eff == POS_CHECK) begin
        pos_d = POS_DONE;
      end else if (pos_eff < POS_CHECK) begin
        pos_d = pos_eff + 4'd1;
      end else begin
        pos_d = pos_eff;
      end
      if (pos_eff == 4'd0) begin
        xor_d = 8'd0;
      end else if (pos_eff < POS_CHECK) begin
        xor_d = xor_q ^ in_byte_i;
      end
      if (pos_eff == POS_SPEED)  fr_d.speed     = in_byte_i;
      if (pos_eff == POS_WHEEL)  fr_d.wheel_nib = in_byte_i[3:0];
      if (pos_eff == POS_FLAGS)  fr_d.flags     = in_byte_i;
      if (pos_eff == POS_TORQUE) fr_d.torque    = in_byte_i;
    end
  end

  assign push_valid_o = accept && (pos_eff == POS_CHECK) && (xor_q == in_byte_i);
  assign push_data_o  = fr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xor_q <= xor_d;
    fr_q  <= fr_d;
  end

endmodule

>>> hdl/tfd_queue.sv
// Short queue of checked frames between the front and back parts.
// Depends on tfd_pkg for the frame type and the depth.
module tfd_queue
  import tfd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  input  frame_t push_data_i,
  output logic   push_ready_o,
  output logic   pop_valid_o,
  output frame_t pop_data_o,
  input  logic   pop_ready_i
);

  frame_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                push_fire, pop_fire;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_fire && !push_fire) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/tfd_back.sv
// Back part: decodes a checked frame into the result fields and holds them in an output register.
// Depends on tfd_pkg for the frame and configuration types and the mode lookup.
module tfd_back
  import tfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       pop_valid_i,
  input  frame_t     pop_data_i,
  output logic       pop_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] speed_o,
  output logic [7:0] flags_o,
  output logic [7:0] torque_o,
  output logic [3:0] wheel_size_o,
  output logic       wheel_known_o,
  output logic [2:0] mode_o
);

  logic       valid_q;
  logic [7:0] speed_q, flags_q, torque_q;
  logic [3:0] wheel_size_q;
  logic       known_q, known;
  logic [2:0] mode_q;
  logic       load;

  assign pop_ready_o = !valid_q || out_ready_i;
  assign load        = pop_valid_i && pop_ready_o;
  assign known       = (pop_data_i.wheel_nib == cfg_i.wheel_code_small) ||
                       (pop_data_i.wheel_nib == cfg_i.wheel_code_large);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      speed_q      <= pop_data_i.speed;
      flags_q      <= pop_data_i.flags & cfg_i.flag_mask;
      torque_q     <= pop_data_i.torque;
      wheel_size_q <= known ? pop_data_i.wheel_nib : 4'd0;
      known_q      <= known;
      mode_q       <= lookup_mode(pop_data_i.torque, cfg_i.torque_table_select);
    end
  end

  assign out_valid_o   = valid_q;
  assign speed_o       = speed_q;
  assign flags_o       = flags_q;
  assign torque_o      = torque_q;
  assign wheel_size_o  = wheel_size_q;
  assign wheel_known_o = known_q;
  assign mode_o        = mode_q;

endmodule

>>> hdl/throttle_frame_deframer_unit.sv
// Throttle frame deframer: top level with the configuration registers.
// Depends on tfd_pkg, tfd_if, tfd_front, tfd_queue and tfd_back.
//
// Received bytes enter on in_i, one item per cycle while in_i is ready.
// A start byte (0xFD) restarts a seven-byte frame; the seventh byte closes
// it, and later bytes are dropped until the next start byte. A frame whose
// checksum byte equals the XOR of bytes one to five gives one item on
// out_o: speed, masked flags, torque, wheel size code and user mode. Bad
// frames give nothing. The result passes through the queue and then the
// output register. Throughput: one byte per cycle unless the queue is full,
// set by the position and XOR update in the front part.
// When out_o stalls, results wait in the output register and a two-entry
// queue; in_i drops ready only when that queue is full.
// Reset clears the byte position, empties the queue and output, and loads
// the register defaults: flag mask 0xF0, wheel codes 8 and 10, table V4.
// Configuration writes through cfg_we_i/cfg_idx_i/cfg_wdata_i take effect
// at once; the user must make them only while no frame is in flight, as the block does not enforce it.
module throttle_frame_deframer_unit
  import tfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tfd_in_if.sink     in_i,
  tfd_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  cfg_t   cfg_q;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  frame_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_mask           <= 8'hF0;
      cfg_q.wheel_code_small    <= 4'd8;
      cfg_q.wheel_code_large    <= 4'd10;
      cfg_q.torque_table_select <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FLAG_MASK:    cfg_q.flag_mask           <= cfg_wdata_i;
        CFG_WHEEL_SMALL:  cfg_q.wheel_code_small    <= cfg_wdata_i[3:0];
        CFG_WHEEL_LARGE:  cfg_q.wheel_code_large    <= cfg_wdata_i[3:0];
        CFG_TABLE_SELECT: cfg_q.torque_table_select <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  tfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_byte_i    (in_i.rx_byte),
    .in_ready_o   (in_i.ready),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  tfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  tfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .pop_valid_i   (pop_valid),
    .pop_data_i    (pop_data),
    .pop_ready_o   (pop_ready),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .speed_o       (out_o.speed),
    .flags_o       (out_o.flags),
    .torque_o      (out_o.torque),
    .wheel_size_o  (out_o.wheel_size),
    .wheel_known_o (out_o.wheel_known),
    .mode_o        (out_o.mode)
  );

endmodule

>>> dv/throttle_frame_deframer_unit_test.sv
`timescale 1ns / 1ps
// Testbench for throttle_frame_deframer_unit: a short table of frames, then random byte
// streams under several register settings, checked against a built-in frame decoder.
// Depends on tfd_pkg, the tfd_in_if/tfd_out_if interfaces and the unit's RTL.
module throttle_frame_deframer_unit_test;
  import tfd_pkg::*;

  localparam int         CLK_HALF     = 5;
  localparam int         RESET_CYCLES = 12;
  localparam int         DRAIN_CYCLES = 6;
  localparam int         CYCLE_LIMIT  = 100000;
  localparam int         PHASES       = 6;
  localparam int         PHASE_ITEMS  = 145;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         MAX_REPORTS  = 10;
  localparam logic [7:0] FRAME_START  = 8'hFD;
  localparam logic [2:0] MODE_NONE    = 3'd6;

  // Torque byte per user mode; row 0 is the V4 table, row 1 the V3X table.
  localparam logic [7:0] MODE_TORQUE [2][6] = '{
    '{8'h00, 8'h05, 8'h07, 8'h09, 8'h0B, 8'h0D},
    '{8'h00, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0D}
  };
  localparam logic [7:0] TORQUE_PICKS [7] = '{8'h00, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0B, 8'h0D};

  typedef struct packed {
    logic [7:0] speed;
    logic [7:0] flags;
    logic [7:0] torque;
    logic [3:0] wheel_size;
    logic       wheel_known;
    logic [2:0] mode;
  } result_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_RESULT, ROW_NONE} row_kind_e;

  // Bytes are packed first byte highest; only the first len bytes are sent.
  typedef struct packed {
    row_kind_e   kind;
    logic [3:0]  len;
    logic [55:0] bytes;
    result_t     want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [5] = '{
    // First frame after reset, collected without a start byte; small wheel, mode 1.
    '{ROW_RESULT,  4'd7, 56'h00_12_38_A5_00_05_8A, '{8'h12, 8'hA0, 8'h05, 4'h8, 1'b1, 3'd1}},
    // A byte after a complete frame is dropped.
    '{ROW_PREDICT, 4'd1, 56'h3C_00_00_00_00_00_00, '0},
    // A start byte in the middle of a frame restarts it.
    '{ROW_PREDICT, 4'd2, 56'hFD_FF_00_00_00_00_00, '0},
    '{ROW_RESULT,  4'd7, 56'hFD_FF_2A_FF_FF_0D_D8, '{8'hFF, 8'hF0, 8'h0D, 4'hA, 1'b1, 3'd5}},
    // Bad checksum: no item.
    '{ROW_NONE,    4'd7, 56'hFD_00_00_00_00_00_01, '0}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = '0;
  logic [7:0] cfg_wdata_i = '0;

  tfd_in_if  in_if ();
  tfd_out_if out_if ();

  throttle_frame_deframer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Decoder state and its copy of the registers, at their reset values.
  logic [7:0] frame_bytes [7];
  logic [3:0] frame_pos    = '0;
  logic [7:0] mask_q       = 8'hF0;
  logic [3:0] code_small_q = 4'd8;
  logic [3:0] code_large_q = 4'd10;
  logic       table_sel_q  = 1'b0;

  result_t pending_results [$];
  int      byte_tag;
  int      mismatches = 0;
  int      cycles     = 0;
  bit      sender_idle_on = 1'b1;
  bit      rx_idle_on     = 1'b1;
  bit      hold_pending   = 1'b0;

  function automatic void note_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t: %s", $time, msg);
    end
    mismatches++;
  endfunction

  // Feeds one received byte to the decoder; returns 1 when it completes a good frame.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [7:0] parity;
    logic [3:0] nib;
    bit         known;
    r = '0;
    if (b == FRAME_START) begin
      frame_pos = '0;
    end
    if (frame_pos < 4'd7) begin
      frame_bytes[frame_pos] = b;
      frame_pos = frame_pos + 4'd1;
    end
    if (frame_pos != 4'd7) begin
      return 1'b0;
    end
    frame_pos = 4'd8;
    parity = frame_bytes[1] ^ frame_bytes[2] ^ frame_bytes[3] ^ frame_bytes[4] ^ frame_bytes[5];
    if (parity != frame_bytes[6]) begin
      return 1'b0;
    end
    nib   = frame_bytes[2][3:0];
    known = (nib == code_small_q) || (nib == code_large_q);
    r.speed       = frame_bytes[1];
    r.flags       = frame_bytes[3] & mask_q;
    r.torque      = frame_bytes[5];
    r.wheel_size  = known ? nib : 4'h0;
    r.wheel_known = known;
    r.mode        = MODE_NONE;
    // Walk down so that the lowest matching index wins.
    for (int i = 5; i >= 0; i--) begin
      if (MODE_TORQUE[table_sel_q][i] == frame_bytes[5]) begin
        r.mode = 3'(i);
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    result_t pred;
    bit      has_pred;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.speed, out_if.flags, out_if.torque, out_if.wheel_size,
                out_if.wheel_known, out_if.mode};
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected item %p", got));
        end else begin
          want = pending_results.pop_front();
          if (got.speed != want.speed || got.flags != want.flags ||
              got.torque != want.torque || got.wheel_size != want.wheel_size ||
              got.wheel_known != want.wheel_known || got.mode != want.mode) begin
            note_mismatch($sformatf("expected %p, got %p", want, got));
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        has_pred = deframe_byte(in_if.rx_byte, pred);
        // Table rows with a typed answer replace the decoder's answer.
        if (byte_tag >= 0) begin
          if (DIRECTED[byte_tag].kind == ROW_RESULT) begin
            pending_results.push_back(DIRECTED[byte_tag].want);
          end
        end else if (has_pred) begin
          pending_results.push_back(pred);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FLAG_MASK:    mask_q       = cfg_wdata_i;
          CFG_WHEEL_SMALL:  code_small_q = cfg_wdata_i[3:0];
          CFG_WHEEL_LARGE:  code_large_q = cfg_wdata_i[3:0];
          CFG_TABLE_SELECT: table_sel_q  = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls per item while rx_idle_on is set, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = rx_idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  task automatic send_item(input logic [7:0] b, input int tag);
    int gap;
    gap = sender_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    byte_tag      <= tag;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Lets a frame that gives no item finish inside the block as well.
  task automatic wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [7:0] mask, input logic [3:0] small_code,
                                input logic [3:0] large_code, input logic sel);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FLAG_MASK;
    cfg_wdata_i <= mask;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_WHEEL_SMALL;
    cfg_wdata_i <= {4'h0, small_code};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_WHEEL_LARGE;
    cfg_wdata_i <= {4'h0, large_code};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TABLE_SELECT;
    cfg_wdata_i <= {7'h0, sel};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly whole frames with random content, some with a broken checksum,
  // plus cut-off frames and loose bytes.
  task automatic run_random_phase(input int quota);
    logic [7:0] fr [7];
    logic [3:0] nib;
    int         sent;
    int         roll;
    int         n;
    sent = 0;
    while (sent < quota) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        case ($urandom_range(0, 2))
          0:       nib = code_small_q;
          1:       nib = code_large_q;
          default: nib = 4'($urandom);
        endcase
        fr[0] = FRAME_START;
        fr[1] = 8'($urandom);
        fr[2] = {4'($urandom), nib};
        fr[3] = 8'($urandom);
        fr[4] = 8'($urandom);
        fr[5] = ($urandom_range(0, 9) < 6) ? TORQUE_PICKS[$urandom_range(0, 6)] : 8'($urandom);
        fr[6] = fr[1] ^ fr[2] ^ fr[3] ^ fr[4] ^ fr[5];
        if ($urandom_range(0, 4) == 0) begin
          fr[6] = fr[6] ^ (8'd1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < 7; i++) begin
          send_item(fr[i], -1);
        end
        sent += 7;
      end else if (roll < 88) begin
        n = $urandom_range(0, 5);
        send_item(FRAME_START, -1);
        for (int i = 0; i < n; i++) begin
          send_item(8'($urandom), -1);
        end
        sent += n + 1;
      end else begin
        // Loose bytes; mostly dropped, so they are not counted.
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          send_item(8'($urandom), -1);
        end
      end
    end
  endtask

  initial begin : stimulus
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    byte_tag      = -1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[r]) begin
      for (int i = 0; i < DIRECTED[r].len; i++) begin
        send_item(DIRECTED[r].bytes[55 - 8 * i -: 8],
                  (DIRECTED[r].kind != ROW_PREDICT && i == DIRECTED[r].len - 1) ? r : -1);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      in_if.valid <= 1'b0;
      wait_idle();
      case (p)
        0:       apply_settings(8'hFF, 4'h0, 4'hF, 1'b1);
        1:       apply_settings(8'h00, 4'hF, 4'h0, 1'b0);
        2: begin
          // Both wheel codes the same.
          n_equal_code:
          begin
            logic [3:0] code;
            code = 4'($urandom);
            apply_settings(8'($urandom), code, code, 1'b1);
          end
        end
        3:       apply_settings(8'hF0, 4'd8, 4'd10, 1'b0);
        default: apply_settings(8'($urandom), 4'($urandom), 4'($urandom), 1'($urandom));
      endcase
      sender_idle_on = (p % 3 != 2);
      rx_idle_on     = (p % 3 != 0);
      // The result side holds off while bytes keep coming, so the block backs up.
      if (p == 1) begin
        hold_pending = 1'b1;
      end
      run_random_phase(PHASE_ITEMS);
    end

    in_if.valid <= 1'b0;
    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
